// File: design/atb_pkg.sv
// Shared types and constants for the alpha template blend block.
// No dependencies; imported by every module of the block.
package atb_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef logic [1:0] draw_mode_t;
    localparam draw_mode_t MODE_JAM1       = 2'd0;
    localparam draw_mode_t MODE_COMPLEMENT = 2'd1;
    localparam draw_mode_t MODE_JAM2       = 2'd2;

    typedef logic [2:0] reg_index_t;
    localparam reg_index_t REG_DRAW_MODE       = 3'd0;
    localparam reg_index_t REG_INVERT_COVERAGE = 3'd1;
    localparam reg_index_t REG_PIXEL_FORMAT    = 3'd2;
    localparam reg_index_t REG_FG_COLOR        = 3'd3;
    localparam reg_index_t REG_BG_COLOR        = 3'd4;

    localparam logic FMT_XRGB8888 = 1'b0;
    localparam logic FMT_RGB565   = 1'b1;

    typedef struct packed {
        draw_mode_t  draw_mode;
        logic        invert_coverage;
        logic        pixel_format;
        logic [23:0] fg_color;
        logic [23:0] bg_color;
    } atb_cfg_t;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] new_pixel;
    } atb_result_t;

endpackage

// File: design/atb_cfg_regs.sv
// APB configuration registers of the alpha template blend block.
// Depends on atb_pkg for the register map and the configuration struct.
module atb_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [atb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [atb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [atb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output atb_pkg::atb_cfg_t                cfg
);
    import atb_pkg::*;

    atb_cfg_t   cfg_reg;
    atb_cfg_t   cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index  = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                REG_DRAW_MODE:       cfg_next.draw_mode       = pwdata[1:0];
                REG_INVERT_COVERAGE: cfg_next.invert_coverage = pwdata[0];
                REG_PIXEL_FORMAT:    cfg_next.pixel_format    = pwdata[0];
                REG_FG_COLOR:        cfg_next.fg_color        = pwdata[23:0];
                REG_BG_COLOR:        cfg_next.bg_color        = pwdata[23:0];
                default:             cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_DRAW_MODE:       prdata = {30'd0, cfg_reg.draw_mode};
            REG_INVERT_COVERAGE: prdata = {31'd0, cfg_reg.invert_coverage};
            REG_PIXEL_FORMAT:    prdata = {31'd0, cfg_reg.pixel_format};
            REG_FG_COLOR:        prdata = {8'd0, cfg_reg.fg_color};
            REG_BG_COLOR:        prdata = {8'd0, cfg_reg.bg_color};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/atb_channel.sv
// One color channel of the blend: rounded JAM1 mix and truncating JAM2 mix.
// Pure combinational; depends on atb_pkg only by convention of the project.
module atb_channel (
    input  logic [7:0] alpha,
    input  logic [7:0] fg,
    input  logic [7:0] bg,
    input  logic [7:0] dst,
    output logic [7:0] jam1,
    output logic [7:0] jam2
);
    import atb_pkg::*;

    logic signed [8:0]  alpha_s;
    logic signed [8:0]  diff1;
    logic signed [8:0]  diff2;
    logic signed [17:0] t1;
    logic signed [17:0] p2;
    logic signed [26:0] t1_ext;
    logic signed [26:0] r1;
    logic signed [17:0] p2_adj;

    assign alpha_s = $signed({1'b0, alpha});
    assign diff1   = $signed({1'b0, fg}) - $signed({1'b0, dst});
    assign diff2   = $signed({1'b0, fg}) - $signed({1'b0, bg});

    assign t1 = alpha_s * diff1;
    assign p2 = alpha_s * diff2;

    // t*257 + 32768, then floor shift by 16; only the low 8 bits survive the add
    assign t1_ext = {{9{t1[17]}}, t1};
    assign r1     = (t1_ext <<< 8) + t1_ext + 27'sd32768;
    assign jam1   = dst + r1[23:16];

    // bias negative products so the shift truncates toward zero
    assign p2_adj = p2 + (p2[17] ? 18'sd255 : 18'sd0);
    assign jam2   = bg + p2_adj[15:8];

endmodule

// File: design/atb_blend.sv
// Per-pixel blend datapath: unpack destination, three channel units, pack, mode select.
// Depends on atb_pkg and atb_channel.
module atb_blend (
    input  atb_pkg::atb_cfg_t    cfg,
    input  logic [7:0]           coverage,
    input  logic [31:0]          dest_pixel,
    output atb_pkg::atb_result_t result
);
    import atb_pkg::*;

    logic [31:0] dest_m;
    logic [7:0]  alpha;
    logic [7:0]  fg_ch [3];
    logic [7:0]  bg_ch [3];
    logic [7:0]  d_ch  [3];
    logic [7:0]  j1_ch [3];
    logic [7:0]  j2_ch [3];
    logic        hit;

    function automatic logic [31:0] pack_pixel(input logic fmt, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b);
        if (fmt == FMT_RGB565) begin
            pack_pixel = {16'd0, r[7:3], g[7:2], b[7:3]};
        end else begin
            pack_pixel = {8'd0, r, g, b};
        end
    endfunction

    assign dest_m = (cfg.pixel_format == FMT_RGB565) ? {16'd0, dest_pixel[15:0]} : dest_pixel;
    assign alpha  = cfg.invert_coverage ? ~coverage : coverage;
    assign hit    = coverage[7] ^ cfg.invert_coverage;

    assign fg_ch[0] = cfg.fg_color[23:16];
    assign fg_ch[1] = cfg.fg_color[15:8];
    assign fg_ch[2] = cfg.fg_color[7:0];
    assign bg_ch[0] = cfg.bg_color[23:16];
    assign bg_ch[1] = cfg.bg_color[15:8];
    assign bg_ch[2] = cfg.bg_color[7:0];

    // RGB565 widens by shifting, no bit replication
    always_comb begin
        if (cfg.pixel_format == FMT_RGB565) begin
            d_ch[0] = {dest_m[15:11], 3'b000};
            d_ch[1] = {dest_m[10:5], 2'b00};
            d_ch[2] = {dest_m[4:0], 3'b000};
        end else begin
            d_ch[0] = dest_m[23:16];
            d_ch[1] = dest_m[15:8];
            d_ch[2] = dest_m[7:0];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        atb_channel u_channel (
            .alpha (alpha),
            .fg    (fg_ch[i]),
            .bg    (bg_ch[i]),
            .dst   (d_ch[i]),
            .jam1  (j1_ch[i]),
            .jam2  (j2_ch[i])
        );
    end

    always_comb begin
        result.write_enable = 1'b0;
        result.new_pixel    = dest_m;
        case (cfg.draw_mode)
            MODE_JAM1: begin
                if (alpha == 8'hFF) begin
                    result.write_enable = 1'b1;
                    result.new_pixel    = pack_pixel(cfg.pixel_format,
                                                     fg_ch[0], fg_ch[1], fg_ch[2]);
                end else if (alpha != 8'h00) begin
                    result.write_enable = 1'b1;
                    result.new_pixel    = pack_pixel(cfg.pixel_format,
                                                     j1_ch[0], j1_ch[1], j1_ch[2]);
                end
            end
            MODE_COMPLEMENT: begin
                if (hit) begin
                    result.write_enable = 1'b1;
                    result.new_pixel    = (cfg.pixel_format == FMT_RGB565) ?
                                          {16'd0, ~dest_m[15:0]} : ~dest_m;
                end
            end
            MODE_JAM2: begin
                result.write_enable = 1'b1;
                result.new_pixel    = pack_pixel(cfg.pixel_format,
                                                 j2_ch[0], j2_ch[1], j2_ch[2]);
            end
            default: begin
                result.write_enable = 1'b0;
                result.new_pixel    = dest_m;
            end
        endcase
    end

endmodule

// File: design/alpha_template_blend_core.sv
// Alpha template blend core: input register, blend datapath, result register.
// Depends on atb_pkg, atb_cfg_regs and atb_blend.
//
// Usage:
//   s_ channel carries one pixel item: s_coverage (template alpha) and
//   s_dest_pixel (current destination pixel). m_ channel returns one item per
//   input: m_write_enable and m_new_pixel. Both use valid/ready.
//   Configuration (draw mode, inverse video, pixel format, fg/bg colors) is
//   written over the APB port while no item is in flight; pready is always high.
//   An accepted item is loaded into the input register, then into the result
//   register once that register is empty or being taken by the receiver.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the single pass through the blend datapath between the two registers.
//   When the receiver stalls, the result register holds; one more item is
//   taken into the input register, after which s_ready drops until m_ready.
//   Reset clears both valid flags and all configuration registers to zero.
module alpha_template_blend_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [atb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [atb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [atb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_coverage,
    input  logic [31:0]                      s_dest_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_write_enable,
    output logic [31:0]                      m_new_pixel
);
    import atb_pkg::*;

    atb_cfg_t    cfg;
    atb_result_t blend_res;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_coverage_reg;
    logic [31:0] in_dest_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_we_reg;
    logic [31:0] out_pixel_reg;
    logic        out_load;
    logic        in_load;

    atb_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    atb_blend u_blend (
        .cfg        (cfg),
        .coverage   (in_coverage_reg),
        .dest_pixel (in_dest_reg),
        .result     (blend_res)
    );

    // advance the result register whenever it is empty or being taken
    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_coverage_reg <= s_coverage;
            in_dest_reg     <= s_dest_pixel;
        end
        if (out_load && in_valid_reg) begin
            out_we_reg    <= blend_res.write_enable;
            out_pixel_reg <= blend_res.new_pixel;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_write_enable = out_we_reg;
    assign m_new_pixel    = out_pixel_reg;

    // a staged item must not be lost while the receiver stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("staged item dropped during stall");

    // a staged item moves into the result register when there is room
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load) |=> out_valid_reg)
        else $error("staged item not moved to result register");

    // a result only appears after an item was staged
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a staged item");

    // never accept into a full, blocked input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_load && in_valid_reg && out_valid_reg && !m_ready))
        else $error("item accepted into a blocked input register");

endmodule

// File: tb/alpha_template_blend_core_test.sv
// Self-checking testbench for alpha_template_blend_core: predicts every result from
// the programmed registers and compares it with the m_ channel. Depends on atb_pkg.
`timescale 1ns / 1ps

module alpha_template_blend_core_test;
    import atb_pkg::*;

    localparam draw_mode_t  MODE_RESERVED = 2'd3;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          PHASE_ITEMS   = 60;
    localparam int          RANDOM_PHASES = 15;
    localparam int          MAX_REPORTS   = 10;

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_coverage;
    logic [31:0]            s_dest_pixel;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_write_enable;
    logic [31:0]            m_new_pixel;

    atb_cfg_t               cur_cfg;
    atb_result_t            pending_pixels[$];
    int                     error_count;
    int unsigned            cycle_count;
    int                     burst_left;
    bit                     sender_gaps_on;
    int                     holds_asked;
    int                     holds_seen;
    int unsigned            stall_left;
    int unsigned            rdy_stretch;
    int unsigned            rdy_style;

    alpha_template_blend_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coverage     (s_coverage),
        .s_dest_pixel   (s_dest_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_new_pixel    (m_new_pixel)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] pack_channels(int ch[3], logic fmt);
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        r = {24'd0, ch[0][7:0]};
        g = {24'd0, ch[1][7:0]};
        b = {24'd0, ch[2][7:0]};
        if (fmt == FMT_RGB565)
            return ((r << 8) & 32'h0000F800) | ((g << 3) & 32'h000007E0) |
                   ((b >> 3) & 32'h0000001F);
        return (r << 16) | (g << 8) | b;
    endfunction

    function automatic atb_result_t blend_pixel(logic [7:0] cov, logic [31:0] dest);
        atb_result_t res;
        logic [31:0] fmask;
        logic [31:0] d;
        logic [7:0]  a;
        int          fgc[3];
        int          bgc[3];
        int          dc[3];
        longint      t;
        bit          hit;
        fmask = (cur_cfg.pixel_format == FMT_RGB565) ? 32'h0000FFFF : 32'hFFFFFFFF;
        d = dest & fmask;
        a = cur_cfg.invert_coverage ? (cov ^ 8'hFF) : cov;
        for (int i = 0; i < 3; i++) begin
            fgc[i] = int'(cur_cfg.fg_color[23 - 8*i -: 8]);
            bgc[i] = int'(cur_cfg.bg_color[23 - 8*i -: 8]);
        end
        if (cur_cfg.pixel_format == FMT_RGB565) begin
            dc[0] = int'((d & 32'h0000F800) >> 8);
            dc[1] = int'((d & 32'h000007E0) >> 3);
            dc[2] = int'((d & 32'h0000001F) << 3);
        end else begin
            dc[0] = int'(d[23:16]);
            dc[1] = int'(d[15:8]);
            dc[2] = int'(d[7:0]);
        end
        res.write_enable = 1'b0;
        res.new_pixel    = d;
        case (cur_cfg.draw_mode)
            MODE_JAM1: begin
                if (a == 8'hFF) begin
                    res.write_enable = 1'b1;
                    res.new_pixel    = pack_channels(fgc, cur_cfg.pixel_format);
                end else if (a != 8'h00) begin
                    // rounded a*v/255 with a floor shift, v may be negative
                    for (int i = 0; i < 3; i++) begin
                        t = longint'(a) * longint'(fgc[i] - dc[i]) * 257 + 32768;
                        dc[i] = dc[i] + int'(t >>> 16);
                    end
                    res.write_enable = 1'b1;
                    res.new_pixel    = pack_channels(dc, cur_cfg.pixel_format);
                end
            end
            MODE_COMPLEMENT: begin
                hit = (cov >= 8'h80);
                if (cur_cfg.invert_coverage)
                    hit = !hit;
                if (hit) begin
                    res.write_enable = 1'b1;
                    res.new_pixel    = ~d;
                end
            end
            MODE_JAM2: begin
                // signed division truncates toward zero
                for (int i = 0; i < 3; i++)
                    dc[i] = bgc[i] + ((fgc[i] - bgc[i]) * int'(a)) / 256;
                res.write_enable = 1'b1;
                res.new_pixel    = pack_channels(dc, cur_cfg.pixel_format);
            end
            default: ;
        endcase
        res.new_pixel = res.new_pixel & fmask;
        return res;
    endfunction

    // ------------------------------------------------------------ result check

    always @(posedge aclk) begin
        atb_result_t exp_px;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= MAX_REPORTS)
                    $display("%0t unexpected item: we=%0b px=%08h",
                             $realtime, m_write_enable, m_new_pixel);
            end else begin
                exp_px = pending_pixels.pop_front();
                if (m_write_enable !== exp_px.write_enable ||
                    m_new_pixel !== exp_px.new_pixel) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t mismatch: expected we=%0b px=%08h, got we=%0b px=%08h",
                                 $realtime, exp_px.write_enable, exp_px.new_pixel,
                                 m_write_enable, m_new_pixel);
                end
            end
        end
    end

    // ----------------------------------------------------------------- receiver

    always @(posedge aclk) begin
        if (holds_seen != holds_asked) begin
            holds_seen <= holds_asked;
            stall_left <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            if (rdy_stretch == 0) begin
                rdy_stretch <= $urandom_range(64, 8);
                rdy_style   <= $urandom_range(3, 0);
            end else begin
                rdy_stretch <= rdy_stretch - 1;
            end
            case (rdy_style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(1, 0));
                2:       m_ready <= ($urandom_range(7, 0) != 0);
                default: m_ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------ drivers

    task automatic send_pixel(input logic [7:0] cov, input logic [31:0] dest);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(2, 0) == 0) ? $urandom_range(8, 1) : 0;
            burst_left = $urandom_range(24, 1);
            if (sender_gaps_on && gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_coverage   <= cov;
        s_dest_pixel <= dest;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_pixels.push_back(blend_pixel(cov, dest));
        burst_left = burst_left - 1;
    endtask

    // Drop valid, wait for every result, then let the pipeline settle.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DRAW_MODE:       cur_cfg.draw_mode       = value[1:0];
            REG_INVERT_COVERAGE: cur_cfg.invert_coverage = value[0];
            REG_PIXEL_FORMAT:    cur_cfg.pixel_format    = value[0];
            REG_FG_COLOR:        cur_cfg.fg_color        = value[23:0];
            REG_BG_COLOR:        cur_cfg.bg_color        = value[23:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input draw_mode_t mode, input logic inv, input logic fmt,
                              input logic [23:0] fg, input logic [23:0] bg);
        drain();
        write_reg(REG_DRAW_MODE, {30'd0, mode});
        write_reg(REG_INVERT_COVERAGE, {31'd0, inv});
        write_reg(REG_PIXEL_FORMAT, {31'd0, fmt});
        write_reg(REG_FG_COLOR, {8'd0, fg});
        write_reg(REG_BG_COLOR, {8'd0, bg});
    endtask

    function automatic logic [7:0] pick_coverage;
        case ($urandom_range(7, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic logic [23:0] pick_color;
        case ($urandom_range(3, 0))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // -------------------------------------------------------------------- tests

    // Registers are all zero out of reset: JAM1 with a black foreground.
    task automatic test_reset_defaults;
        send_pixel(8'h00, 32'hFFFFFFFF);
        send_pixel(8'hFF, 32'hFFFFFFFF);
        send_pixel(8'h80, 32'h00A5C3E7);
    endtask

    task automatic test_jam1;
        set_config(MODE_JAM1, 1'b0, FMT_XRGB8888, 24'hFFFFFF, 24'h000000);
        send_pixel(8'h00, 32'h12345678);
        send_pixel(8'h01, 32'h00000000);
        send_pixel(8'h7F, 32'hFF000000);
        send_pixel(8'hFE, 32'h00808080);
        send_pixel(8'hFF, 32'hFFFFFFFF);
        // inverse video: coverage 0xff becomes no write
        set_config(MODE_JAM1, 1'b1, FMT_XRGB8888, 24'h0080FF, 24'h000000);
        send_pixel(8'hFF, 32'hFFFFFFFF);
        send_pixel(8'h00, 32'h00FF8000);
    endtask

    task automatic test_complement;
        set_config(MODE_COMPLEMENT, 1'b0, FMT_XRGB8888, 24'h000000, 24'h000000);
        send_pixel(8'h7F, 32'h0F0F0F0F);
        send_pixel(8'h80, 32'h0F0F0F0F);
        send_pixel(8'hFF, 32'h00000000);
        set_config(MODE_COMPLEMENT, 1'b1, FMT_RGB565, 24'h000000, 24'h000000);
        send_pixel(8'h7F, 32'hFFFF1234);
        send_pixel(8'h80, 32'hFFFF1234);
        send_pixel(8'h00, 32'hA5A50000);
    endtask

    task automatic test_jam2;
        // foreground below background drives the negative truncation path
        set_config(MODE_JAM2, 1'b0, FMT_XRGB8888, 24'h00107F, 24'hFF80FF);
        send_pixel(8'h00, 32'hFFFFFFFF);
        send_pixel(8'hFF, 32'h00000000);
        send_pixel(8'h81, 32'h12345678);
        set_config(MODE_JAM2, 1'b1, FMT_RGB565, 24'hFFFFFF, 24'h000000);
        send_pixel(8'h00, 32'hFFFFFFFF);
        send_pixel(8'h40, 32'h0000F81F);
    endtask

    task automatic test_rgb565_jam1;
        set_config(MODE_JAM1, 1'b0, FMT_RGB565, 24'hFF00FF, 24'h000000);
        send_pixel(8'h80, 32'hFFFFFFFF);
        send_pixel(8'hFF, 32'hABCD07E0);
        send_pixel(8'h00, 32'h5555AAAA);
    endtask

    task automatic test_reserved_mode;
        set_config(MODE_RESERVED, 1'b1, FMT_XRGB8888, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(8'hFF, 32'hDEADBEEF);
        send_pixel(8'h80, 32'h01234567);
    endtask

    task automatic test_random_settings;
        draw_mode_t      mode;
        logic [23:0]     fg;
        logic [23:0]     bg;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = ($urandom_range(9, 0) == 0) ? MODE_RESERVED
                                               : draw_mode_t'($urandom_range(2, 0));
            fg = (p == 0) ? 24'hFFFFFF : (p == 1) ? 24'h000000 : pick_color();
            bg = (p == 0) ? 24'h000000 : (p == 1) ? 24'hFFFFFF : pick_color();
            set_config(mode, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), fg, bg);
            // every few phases, run back to back with no sender gaps
            sender_gaps_on = ($urandom_range(3, 0) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(pick_coverage(), 32'($urandom));
        end
        sender_gaps_on = 1'b1;
    endtask

    // Hold the receiver off long enough that the block fills and stalls s_ready.
    task automatic test_backpressure;
        set_config(MODE_JAM1, 1'b0, FMT_XRGB8888, pick_color(), pick_color());
        sender_gaps_on = 1'b0;
        holds_asked = holds_asked + 1;
        for (int n = 0; n < 40; n++)
            send_pixel(pick_coverage(), 32'($urandom));
        sender_gaps_on = 1'b1;
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_coverage     = 8'h00;
        s_dest_pixel   = 32'h0;
        m_ready        = 1'b0;
        cur_cfg        = '0;
        error_count    = 0;
        cycle_count    = 0;
        burst_left     = 0;
        sender_gaps_on = 1'b1;
        holds_asked    = 0;
        holds_seen     = 0;
        stall_left     = 0;
        rdy_stretch    = 0;
        rdy_style      = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_jam1();
        test_complement();
        test_jam2();
        test_rgb565_jam1();
        test_reserved_mode();
        test_backpressure();
        test_random_settings();
        drain();

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
design/atb_pkg.sv
design/atb_cfg_regs.sv
design/atb_channel.sv
design/atb_blend.sv
design/alpha_template_blend_core.sv
tb/alpha_template_blend_core_test.sv
